@@ design/checkpoint_order_deadline_monitor_macros.svh @@
// ----------------------------------------------------------------------------
// checkpoint order deadline monitor assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef CHECKPOINT_ORDER_DEADLINE_MONITOR_MACROS_SVH
`define CHECKPOINT_ORDER_DEADLINE_MONITOR_MACROS_SVH

// checked only while out of reset
`define CPODM_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define CPODM_ASSERT_ON(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/cpodm_pkg.sv @@
// ----------------------------------------------------------------------------
// cpodm_pkg
// shared types, constants and helpers of the checkpoint order deadline monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpodm_pkg;

	localparam int MAX_CHECKPOINTS_DEF = 16;
	localparam int ID_W   = 4;
	localparam int TIME_W = 32;
	localparam int CNT_W  = 8;
	localparam int CFG_W  = 5;
	localparam int MAX_W  = 8;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
	localparam logic [CNT_W-1:0] CNT_SAT   = 8'hFF;

	typedef enum logic [1:0] {
		MODE_INIT         = 2'd0,
		MODE_CHECKPOINT   = 2'd1,
		MODE_POLL         = 2'd2,
		MODE_WRITE_LIMITS = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [ID_W-1:0]    id;
		logic [TIME_W-1:0]  now;
		logic [TIME_W-1:0]  mn;
		logic [TIME_W-1:0]  mx;
	} item_t;

	typedef struct packed {
		logic               en;
		logic [ID_W-1:0]    idx;
		logic [TIME_W-1:0]  mn;
		logic [TIME_W-1:0]  mx;
	} lim_wr_t;

	typedef struct packed {
		logic               ok;
		logic [CNT_W-1:0]   order_errors;
		logic [CNT_W-1:0]   early_errors;
		logic [CNT_W-1:0]   late_errors;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_SAT) ? c : c + 8'd1;
	endfunction

endpackage

@@ design/cpodm_limits.sv @@
// ----------------------------------------------------------------------------
// cpodm_limits
// per-checkpoint min/max limit store, one write and one read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpodm_limits #(
	parameter int MAX_CHECKPOINTS = cpodm_pkg::MAX_CHECKPOINTS_DEF
) (
	input  logic                           clk,
	input  cpodm_pkg::lim_wr_t             wr,
	input  logic [cpodm_pkg::ID_W-1:0]     rd_id,
	output logic [cpodm_pkg::TIME_W-1:0]   rd_mn,
	output logic [cpodm_pkg::TIME_W-1:0]   rd_mx
);
	import cpodm_pkg::*;

	// ids are only ID_W bits wide, so entries past that are unreachable
	localparam int DEPTH = (MAX_CHECKPOINTS < (1 << ID_W)) ? MAX_CHECKPOINTS : (1 << ID_W);
	localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [MAX_W-1:0] MAX_V = MAX_W'(MAX_CHECKPOINTS);

	logic [TIME_W-1:0] mn_mem [DEPTH];
	logic [TIME_W-1:0] mx_mem [DEPTH];
	logic              wr_hit;
	logic              rd_hit;

	assign wr_hit = wr.en && ({{(MAX_W-ID_W){1'b0}}, wr.idx} < MAX_V);
	assign rd_hit = {{(MAX_W-ID_W){1'b0}}, rd_id} < MAX_V;

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mn_mem[wr.idx[IDXW-1:0]] <= wr.mn;
			mx_mem[wr.idx[IDXW-1:0]] <= wr.mx;
		end
	end

	// ids beyond the store read as zero limits
	always_comb begin
		rd_mn = '0;
		rd_mx = '0;
		if (rd_hit) begin
			rd_mn = mn_mem[rd_id[IDXW-1:0]];
			rd_mx = mx_mem[rd_id[IDXW-1:0]];
		end
	end

endmodule

@@ design/cpodm_core.sv @@
// ----------------------------------------------------------------------------
// cpodm_core
// order and deadline checks, supervision state and error counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "checkpoint_order_deadline_monitor_macros.svh"

module cpodm_core #(
	parameter int MAX_CHECKPOINTS = cpodm_pkg::MAX_CHECKPOINTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  cpodm_pkg::item_t             item,
	input  logic [cpodm_pkg::CFG_W-1:0]  count,
	output cpodm_pkg::res_t              res
);
	import cpodm_pkg::*;

	localparam logic [MAX_W-1:0] MAX_V = MAX_W'(MAX_CHECKPOINTS);

	logic              seen_q;
	logic [ID_W-1:0]   last_id_q;
	logic [TIME_W-1:0] last_time_q;
	logic [CNT_W-1:0]  order_q, early_q, late_q;

	logic              seen_d;
	logic [ID_W-1:0]   last_id_d;
	logic [TIME_W-1:0] last_time_d;
	logic [CNT_W-1:0]  order_d, early_d, late_d;

	logic [MAX_W-1:0]  count_w, n_eff, nx;
	logic [ID_W-1:0]   exp_id, sel_id;
	logic [TIME_W-1:0] lim_mn, lim_mx, elapsed;
	logic              check_on, early_bad, late_bad, order_ok, ok;
	lim_wr_t           wr;

	assign count_w = {{(MAX_W-CFG_W){1'b0}}, count};
	assign n_eff   = (count == '0) ? MAX_W'(1) : ((count_w > MAX_V) ? MAX_V : count_w);
	assign nx      = {{(MAX_W-ID_W){1'b0}}, last_id_q} + MAX_W'(1);
	// nx below n_eff implies it fits in an id
	assign exp_id  = (nx >= n_eff) ? '0 : nx[ID_W-1:0];
	assign sel_id  = (item.mode == MODE_CHECKPOINT) ? item.id : exp_id;

	assign wr.en  = fire && (item.mode == MODE_WRITE_LIMITS);
	assign wr.idx = item.id;
	assign wr.mn  = item.mn;
	assign wr.mx  = item.mx;

	cpodm_limits #(
		.MAX_CHECKPOINTS(MAX_CHECKPOINTS)
	) u_limits (
		.clk   (clk),
		.wr    (wr),
		.rd_id (sel_id),
		.rd_mn (lim_mn),
		.rd_mx (lim_mx)
	);

	// wrap case is all-ones minus last plus now, one short of modular
	assign elapsed   = (item.now >= last_time_q) ? (item.now - last_time_q)
	                                              : (~last_time_q + item.now);
	assign check_on  = (lim_mn != '0) || (lim_mx != '0);
	assign early_bad = lim_mn > elapsed;
	assign late_bad  = lim_mx < elapsed;
	assign order_ok  = seen_q ? (exp_id == item.id) : (item.id == '0);

	always_comb begin
		seen_d      = seen_q;
		last_id_d   = last_id_q;
		last_time_d = last_time_q;
		order_d     = order_q;
		early_d     = early_q;
		late_d      = late_q;
		ok          = 1'b1;
		case (item.mode)
			MODE_INIT: begin
				seen_d      = 1'b0;
				last_time_d = '0;
				order_d     = '0;
				early_d     = '0;
				late_d      = '0;
			end
			MODE_CHECKPOINT: begin
				order_d = order_ok ? '0 : sat_inc(order_q);
				ok      = order_ok;
				if (seen_q && check_on) begin
					early_d = early_bad ? sat_inc(early_q) : '0;
					late_d  = late_bad ? sat_inc(late_q) : '0;
					ok      = order_ok && !early_bad && !late_bad;
				end
				seen_d      = 1'b1;
				last_id_d   = item.id;
				last_time_d = item.now;
			end
			MODE_POLL: begin
				if (seen_q && check_on) begin
					early_d = early_bad ? sat_inc(early_q) : '0;
					late_d  = late_bad ? sat_inc(late_q) : '0;
					ok      = !early_bad && !late_bad;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_id_q   <= '0;
			last_time_q <= '0;
			order_q     <= '0;
			early_q     <= '0;
			late_q      <= '0;
		end else if (fire) begin
			seen_q      <= seen_d;
			last_id_q   <= last_id_d;
			last_time_q <= last_time_d;
			order_q     <= order_d;
			early_q     <= early_d;
			late_q      <= late_d;
		end
	end

	assign res.ok           = ok;
	assign res.order_errors = order_d;
	assign res.early_errors = early_d;
	assign res.late_errors  = late_d;

	`CPODM_ASSERT_RST(a_init_clears, (fire && item.mode == MODE_INIT) |=> (!seen_q && order_q == '0 && early_q == '0 && late_q == '0), "init request did not clear supervision state")
	`CPODM_ASSERT_RST(a_ok_checkpoint_order, (fire && item.mode == MODE_CHECKPOINT && ok) |-> (order_d == '0), "passing checkpoint left a nonzero order count")

endmodule

@@ design/checkpoint_order_deadline_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checkpoint_order_deadline_monitor
// program flow and deadline supervisor with saturating error counters
// ----------------------------------------------------------------------------
// usage:
//  s_* carries one request: tuser = mode (init, checkpoint, poll, limits write),
//  tdata = checkpoint id, current time and the two limits for a write.
//  m_* returns exactly one result per request: ok and the three counters.
//  cfg_wr_en/cfg_wr_data set the length of the checkpoint cycle; write it only
//  while no request is in flight.
//  each request passes the input register, then the result register; one
//  request per cycle is sustained while m_tready is high, since the limit
//  lookup, one subtract and two compares fit between the two registers.
//  reset clears the counters, the checkpoint history and the cycle length
//  goes to 16; the limit store is not cleared and must be written before use.
//  when m_tready is low the result holds, an empty input stage still takes
//  one more request, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------

`include "checkpoint_order_deadline_monitor_macros.svh"

module checkpoint_order_deadline_monitor #(
	parameter int MAX_CHECKPOINTS = cpodm_pkg::MAX_CHECKPOINTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [cpodm_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// checkpoint_id[3:0], current_time[35:4], min_limit[67:36], max_limit[99:68]
	input  logic [103:0]                 s_tdata,
	// mode[1:0]
	input  logic [1:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// ok[0], order_errors[8:1], early_errors[16:9], late_errors[24:17]
	output logic [31:0]                  m_tdata
);
	import cpodm_pkg::*;

	logic [CFG_W-1:0] count_q;
	logic             valid_s1, valid_s2;
	item_t            item_s1;
	res_t             res, res_s2;
	logic             fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode <= mode_t'(s_tuser);
			item_s1.id   <= s_tdata[3:0];
			item_s1.now  <= s_tdata[35:4];
			item_s1.mn   <= s_tdata[67:36];
			item_s1.mx   <= s_tdata[99:68];
		end
	end

	cpodm_core #(
		.MAX_CHECKPOINTS(MAX_CHECKPOINTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.count  (count_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0, res_s2.late_errors, res_s2.early_errors,
	                   res_s2.order_errors, res_s2.ok};

	`CPODM_ASSERT_RST(a_fire_gives_result, fire |=> m_tvalid, "processed request produced no result")
	`CPODM_ASSERT_RST(a_empty_stage_ready, !valid_s1 |-> s_tready, "empty input stage refused a request")
	`CPODM_ASSERT_ON(a_reset_no_result, !arst_n |=> !m_tvalid, "result valid during reset")

endmodule

@@ dv/tb_checkpoint_order_deadline_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checkpoint_order_deadline_monitor
// self-checking bench: drives init, checkpoint, poll and limit-write requests,
// predicts ok and the three error counters per request, and compares every
// result in order under random idling, a long output hold-off and several
// cycle lengths
// ----------------------------------------------------------------------------

module tb_checkpoint_order_deadline_monitor;

	import cpodm_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]    cfg_wr_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// checkpoint_id[3:0], current_time[35:4], min_limit[67:36], max_limit[99:68]
	logic [103:0]        s_tdata = '0;
	// mode[1:0]
	logic [1:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// ok[0], order_errors[8:1], early_errors[16:9], late_errors[24:17]
	logic [31:0]         m_tdata;

	checkpoint_order_deadline_monitor uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// supervisor state as predicted
	logic [CFG_W-1:0]    cycle_len = CFG_RESET;
	bit                  seen = 1'b0;
	logic [ID_W-1:0]     last_id = '0;
	logic [TIME_W-1:0]   last_tick = '0;
	logic [CNT_W-1:0]    cnt_order = '0;
	logic [CNT_W-1:0]    cnt_early = '0;
	logic [CNT_W-1:0]    cnt_late = '0;
	logic [TIME_W-1:0]   lim_min [MAX_CHECKPOINTS_DEF];
	logic [TIME_W-1:0]   lim_max [MAX_CHECKPOINTS_DEF];

	res_t                pending_verdicts [$];
	int                  n_requests = 0;
	int                  n_results = 0;
	int                  mismatches = 0;
	int                  tx_max_gap = 15;
	int                  rx_max_stall = 15;
	int                  rx_hold_cycles = 0;

	function automatic logic [CNT_W-1:0] bump_sat(logic [CNT_W-1:0] c);
		return (c == CNT_SAT) ? c : c + 1'b1;
	endfunction

	function automatic logic [ID_W-1:0] upcoming_id();
		int n;
		int nx;
		n = int'(cycle_len);
		if (n < 1) n = 1;
		if (n > MAX_CHECKPOINTS_DEF) n = MAX_CHECKPOINTS_DEF;
		nx = int'(last_id) + 1;
		return (nx >= n) ? '0 : ID_W'(nx);
	endfunction

	// updates the early/late counters, returns 1 when within the window
	function automatic bit deadline_ok(logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		logic [TIME_W-1:0] span;
		bit good;
		lo = lim_min[id];
		hi = lim_max[id];
		good = 1'b1;
		if (lo == '0 && hi == '0) return 1'b1;
		// wrapped case is one short of the modular difference
		span = (now >= last_tick) ? now - last_tick : 32'hFFFF_FFFF - last_tick + now;
		if (lo > span) begin
			cnt_early = bump_sat(cnt_early);
			good = 1'b0;
		end else begin
			cnt_early = '0;
		end
		if (hi < span) begin
			cnt_late = bump_sat(cnt_late);
			good = 1'b0;
		end else begin
			cnt_late = '0;
		end
		return good;
	endfunction

	function automatic res_t supervise(item_t it);
		res_t r;
		r.ok = 1'b1;
		case (it.mode)
			MODE_INIT: begin
				last_tick = '0;
				cnt_order = '0;
				cnt_early = '0;
				cnt_late = '0;
				seen = 1'b0;
			end
			MODE_CHECKPOINT: begin
				if (!seen) begin
					if (it.id != '0) begin
						cnt_order = bump_sat(cnt_order);
						r.ok = 1'b0;
					end else begin
						cnt_order = '0;
					end
				end else begin
					if (upcoming_id() == it.id) begin
						cnt_order = '0;
					end else begin
						cnt_order = bump_sat(cnt_order);
						r.ok = 1'b0;
					end
					if (!deadline_ok(it.id, it.now)) r.ok = 1'b0;
				end
				last_id = it.id;
				last_tick = it.now;
				seen = 1'b1;
			end
			MODE_POLL: begin
				if (seen) r.ok = deadline_ok(upcoming_id(), it.now);
			end
			default: begin
				lim_min[it.id] = it.mn;
				lim_max[it.id] = it.mx;
			end
		endcase
		r.order_errors = cnt_order;
		r.early_errors = cnt_early;
		r.late_errors = cnt_late;
		return r;
	endfunction

	function automatic item_t make_item(mode_t m, logic [ID_W-1:0] id,
			logic [TIME_W-1:0] now, logic [TIME_W-1:0] mn, logic [TIME_W-1:0] mx);
		item_t it;
		it.mode = m;
		it.id = id;
		it.now = now;
		it.mn = mn;
		it.mx = mx;
		return it;
	endfunction

	task automatic send_request(input item_t it);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, it.mx, it.mn, it.now, it.id};
		s_tuser <= it.mode;
		do @(posedge clk); while (!s_tready);
		pending_verdicts.push_back(supervise(it));
		n_requests++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		// two-stage pipe, allow a few extra edges
		repeat (4) @(posedge clk);
	endtask

	task automatic set_cycle_len(input logic [CFG_W-1:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cycle_len = v;
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch at result %0d: %s got %0d want %0d", n_results, what, got, want);
	endtask

	// result checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok = m_tdata[0];
			got.order_errors = m_tdata[8:1];
			got.early_errors = m_tdata[16:9];
			got.late_errors = m_tdata[24:17];
			n_results++;
			if (pending_verdicts.size() == 0) begin
				flag_mismatch("result with no request outstanding", m_tdata, 0);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.ok != want.ok) flag_mismatch("ok", got.ok, want.ok);
				if (got.order_errors != want.order_errors)
					flag_mismatch("order_errors", got.order_errors, want.order_errors);
				if (got.early_errors != want.early_errors)
					flag_mismatch("early_errors", got.early_errors, want.early_errors);
				if (got.late_errors != want.late_errors)
					flag_mismatch("late_errors", got.late_errors, want.late_errors);
			end
		end
	end

	// result sink with random stalls and an optional long hold-off
	initial begin : result_sink
		int stall;
		forever begin
			if (rx_hold_cycles != 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				stall = $urandom_range(0, rx_max_stall);
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic item_t random_request();
		int pick;
		logic [TIME_W-1:0] step;
		logic [TIME_W-1:0] lo;
		logic [ID_W-1:0] nxt;
		pick = $urandom_range(0, 99);
		step = $urandom_range(0, 60);
		nxt = seen ? upcoming_id() : '0;
		if (pick < 55)
			return make_item(MODE_CHECKPOINT, nxt, last_tick + step, $urandom, $urandom);
		if (pick < 67)
			return make_item(MODE_POLL, ID_W'($urandom_range(0, 15)), last_tick + step,
				$urandom, $urandom);
		if (pick < 75) begin
			case ($urandom_range(0, 3))
				0: return make_item(MODE_WRITE_LIMITS, ID_W'($urandom_range(0, 15)),
					$urandom, 0, 0);
				1: return make_item(MODE_WRITE_LIMITS, ID_W'($urandom_range(0, 15)),
					$urandom, $urandom, $urandom);
				2: begin
					lo = $urandom_range(0, 30);
					return make_item(MODE_WRITE_LIMITS, ID_W'($urandom_range(0, 15)),
						$urandom, lo, lo + $urandom_range(0, 40));
				end
				default: return make_item(MODE_WRITE_LIMITS, ID_W'($urandom_range(0, 15)),
					$urandom, 0, $urandom_range(1, 60));
			endcase
		end
		if (pick < 78)
			return make_item(MODE_INIT, ID_W'($urandom_range(0, 15)), $urandom, $urandom,
				$urandom);
		if (pick < 90)
			return make_item(MODE_CHECKPOINT, ID_W'($urandom_range(0, 15)), last_tick + step,
				0, 0);
		// park the time near the top so later requests wrap
		if (pick < 95)
			return make_item(MODE_CHECKPOINT, nxt, 32'hFFFF_FFFF - $urandom_range(0, 40), 0, 0);
		return make_item(($urandom_range(0, 1) != 0) ? MODE_POLL : MODE_CHECKPOINT,
			ID_W'($urandom_range(0, 15)), $urandom, 0, 0);
	endfunction

	// every entry gets written before any time check can read it
	task automatic test_load_limits();
		for (int i = 0; i < MAX_CHECKPOINTS_DEF; i++) begin
			if (i == 0)
				send_request(make_item(MODE_WRITE_LIMITS, ID_W'(i), 0, 0, 0));
			else if (i == MAX_CHECKPOINTS_DEF - 1)
				send_request(make_item(MODE_WRITE_LIMITS, ID_W'(i), 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 32'hFFFF_FFFF));
			else
				send_request(make_item(MODE_WRITE_LIMITS, ID_W'(i), $urandom, 10, 40));
		end
	endtask

	task automatic test_directed();
		send_request(make_item(MODE_INIT, 0, 0, 0, 0));
		// poll before any checkpoint
		send_request(make_item(MODE_POLL, 4'd15, 32'hFFFF_FFFF, 0, 0));
		// first checkpoint must be zero
		send_request(make_item(MODE_CHECKPOINT, 4'd3, 32'd50, 0, 0));
		send_request(make_item(MODE_INIT, 0, 32'd77, 0, 0));
		send_request(make_item(MODE_CHECKPOINT, 4'd0, 32'd100, 0, 0));
		send_request(make_item(MODE_CHECKPOINT, 4'd1, 32'd120, 0, 0));
		send_request(make_item(MODE_POLL, 0, 32'd125, 0, 0));
		send_request(make_item(MODE_POLL, 0, 32'd200, 0, 0));
		send_request(make_item(MODE_CHECKPOINT, 4'd2, 32'd125, 0, 0));
		// skip checkpoint 3
		send_request(make_item(MODE_CHECKPOINT, 4'd4, 32'd150, 0, 0));
		send_request(make_item(MODE_CHECKPOINT, 4'd5, 32'hFFFF_FFF0, 0, 0));
		// tick counter wraps between these two
		send_request(make_item(MODE_CHECKPOINT, 4'd6, 32'h0000_0010, 0, 0));
		send_request(make_item(MODE_CHECKPOINT, 4'd15, 32'h0000_0020, 0, 0));
		send_request(make_item(MODE_CHECKPOINT, 4'd0, 32'h0000_0030, 0, 0));
		send_request(make_item(MODE_POLL, 0, 32'hFFFF_FFFF, 0, 0));
		send_request(make_item(MODE_CHECKPOINT, 4'd1, 32'h0000_0000, 0, 0));
	endtask

	// short cycles, zero and oversized counts saturate into range
	task automatic test_cycle_length();
		logic [CFG_W-1:0] lens [4];
		logic [TIME_W-1:0] t;
		int eff;
		lens = '{5'd0, 5'd1, 5'd2, 5'd31};
		foreach (lens[k]) begin
			set_cycle_len(lens[k]);
			send_request(make_item(MODE_INIT, 0, 0, 0, 0));
			t = 32'd1000;
			eff = (lens[k] < 1) ? 1 : ((lens[k] > MAX_CHECKPOINTS_DEF) ?
				MAX_CHECKPOINTS_DEF : lens[k]);
			for (int j = 0; j <= eff; j++) begin
				send_request(make_item(MODE_CHECKPOINT, seen ? upcoming_id() : 4'd0, t, 0, 0));
				t += 20;
			end
			send_request(make_item(MODE_CHECKPOINT, upcoming_id() + 4'd1, t, 0, 0));
		end
		set_cycle_len(CFG_RESET);
	endtask

	// min above max on one entry: every visit is early, late and out of order
	task automatic test_saturation();
		logic [TIME_W-1:0] t;
		tx_max_gap = 0;
		rx_max_stall = 0;
		send_request(make_item(MODE_WRITE_LIMITS, 4'd7, 0, 32'hFFFF_FFFF, 32'd0));
		send_request(make_item(MODE_INIT, 0, 0, 0, 0));
		t = 32'd500;
		send_request(make_item(MODE_CHECKPOINT, 4'd0, t, 0, 0));
		repeat (270) begin
			t += 3;
			send_request(make_item(MODE_CHECKPOINT, 4'd7, t, 0, 0));
		end
		send_request(make_item(MODE_WRITE_LIMITS, 4'd8, 0, 32'd10, 32'd40));
		send_request(make_item(MODE_CHECKPOINT, 4'd8, t + 20, 0, 0));
		tx_max_gap = 15;
		rx_max_stall = 15;
	endtask

	task automatic test_backpressure();
		tx_max_gap = 0;
		rx_hold_cycles = 300;
		repeat (40) send_request(random_request());
		wait_idle();
		tx_max_gap = 15;
	endtask

	task automatic test_random();
		logic [CFG_W-1:0] lens [7];
		lens = '{5'd16, 5'd0, 5'd31, 5'd1, 5'($urandom_range(2, 15)),
			5'($urandom_range(17, 31)), 5'd3};
		foreach (lens[p]) begin
			set_cycle_len(lens[p]);
			for (int i = 0; i < 50; i++) begin
				if (i % 25 == 0) begin
					tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 15;
					rx_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 15;
				end
				send_request(random_request());
			end
		end
		tx_max_gap = 15;
		rx_max_stall = 15;
	endtask

	initial begin : main
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_limits();
		test_directed();
		test_cycle_length();
		test_saturation();
		test_backpressure();
		test_random();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("requests sent: %0d, results checked: %0d, mismatches: %0d",
			n_requests, n_results, mismatches);
		$display("covered order and window errors, tick wrap, counter saturation, cycle "
			, "lengths 0..31 and a long output hold-off");
		if (mismatches == 0 && pending_verdicts.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
